[rtl/core/evct_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evct_pkg
// Shared types and constants for the event cartridge timer and rom mapper.
// ----------------------------------------------------------------------------
package evct_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_STATUS = 3'd1,
    CMD_SELECT = 3'd2,
    CMD_ROM    = 3'd3,
    CMD_RAM_RD = 3'd4,
    CMD_RAM_WR = 3'd5
  } evct_cmd_t;

  // configuration register indexes
  localparam logic [2:0] REG_BOARD = 3'd0;
  localparam logic [2:0] REG_TIMER = 3'd1;
  localparam logic [2:0] REG_CHIP0 = 3'd2;
  localparam logic [2:0] REG_CHIP1 = 3'd3;
  localparam logic [2:0] REG_CHIP2 = 3'd4;
  localparam logic [2:0] REG_CHIP3 = 3'd5;

  localparam logic [1:0] BOARD_CAMPUS    = 2'd1;
  localparam logic [1:0] BOARD_POWERFEST = 2'd2;

  localparam logic [7:0] SEL_GAME_START = 8'h09;
  localparam logic [7:0] SEL_CAMPUS_2   = 8'h05;
  localparam logic [7:0] SEL_CAMPUS_3   = 8'h03;
  localparam logic [7:0] SEL_POWER_2    = 8'h0c;
  localparam logic [7:0] SEL_POWER_3    = 8'h0a;

  localparam logic [23:0] CAMPUS_CHIP0_MASK = 24'h808000;
  localparam logic [23:0] POWER_CHIP0_MASK  = 24'h208000;
  localparam logic [23:0] BANK_LO_MASK      = 24'h7f0000;
  localparam logic [23:0] POWER_BANK_MASK   = 24'h1f0000;
  localparam logic [23:0] OFFSET_MASK       = 24'h007fff;
  localparam logic [23:0] POWER_HI_MASK     = 24'h3fffff;
  localparam logic [23:0] POWER_LO_MASK     = 24'h1fffff;

  localparam logic [4:0] LOG2_MIN = 5'd10;
  localparam logic [4:0] LOG2_MAX = 5'd22;

  localparam logic [2:0] SCORE_SECONDS = 3'd5;
  localparam int         STATUS_TIME_OVER_BIT = 1;

  typedef struct packed {
    logic       time_over;
    logic       score_fire;
    logic [7:0] select_value;
  } evct_timer_status_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  chip;
    logic [21:0] address;
  } evct_rom_result_t;

endpackage

[rtl/core/event_cart_timer_and_rom_mapper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_cart_timer_and_rom_mapper
// Contest cartridge controller: game timer, score countdown, ROM mapper and
// internal work RAM behind one command stream.
// ----------------------------------------------------------------------------
// One command word is taken per clock while s_tready is high, a sustained
// rate while m_tready stays high, and gives one result word from stage a
// and the output register, as the RAM read port has a registered output.
// After reset the work RAM is swept to zero, one entry per cycle, with
// s_tready low until the sweep ends; configuration writes are taken during
// the sweep. RAM_DEPTH must be a power of two: RAM addresses wrap on its
// low bits. Write configuration only while no command is in flight.
module event_cart_timer_and_rom_mapper import evct_pkg::*; #(
  parameter int RAM_DEPTH = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] command, [26:3] address, [34:27] write_data, [39:35] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] read_data, [9:8] rom_chip, [31:10] rom_address, [32] rom_hit,
  // [33] score_ready, [39:34] zero
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int RAM_AW = $clog2(RAM_DEPTH);

  // configuration
  logic [1:0]  board_kind;
  logic [15:0] timer_seconds;
  logic [4:0]  chip_log2 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      board_kind    <= 2'd0;
      timer_seconds <= 16'd0;
      for (int i = 0; i < 4; i++) chip_log2[i] <= LOG2_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOARD: board_kind    <= cfg_data[1:0];
        REG_TIMER: timer_seconds <= cfg_data;
        REG_CHIP0: chip_log2[0]  <= cfg_data[4:0];
        REG_CHIP1: chip_log2[1]  <= cfg_data[4:0];
        REG_CHIP2: chip_log2[2]  <= cfg_data[4:0];
        REG_CHIP3: chip_log2[3]  <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // input word
  evct_cmd_t   cmd;
  logic [23:0] address;
  logic [7:0]  write_data;

  assign cmd        = evct_cmd_t'(s_tdata[2:0]);
  assign address    = s_tdata[26:3];
  assign write_data = s_tdata[34:27];

  logic accept;
  logic ram_busy;
  logic a_valid;
  logic a_advance;
  logic o_valid;

  assign a_advance = a_valid && (!o_valid || m_tready);
  assign s_tready  = !ram_busy && (!a_valid || a_advance);
  assign accept    = s_tvalid && s_tready;

  evct_timer_status_t tstat;
  evct_rom_result_t   rom;
  logic [7:0]         ram_q;

  evct_timer u_timer (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .cmd           (cmd),
    .write_data    (write_data),
    .timer_seconds (timer_seconds),
    .status        (tstat)
  );

  evct_rom_map u_rom_map (
    .board_kind   (board_kind),
    .select_value (tstat.select_value),
    .address      (address),
    .chip_log2    (chip_log2),
    .result       (rom)
  );

  evct_ram #(
    .DEPTH (RAM_DEPTH),
    .AW    (RAM_AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .addr  (address[RAM_AW-1:0]),
    .wr_en (accept && (cmd == CMD_RAM_WR)),
    .wdata (write_data),
    .rd_en (accept && (cmd == CMD_RAM_RD)),
    .rdata (ram_q),
    .busy  (ram_busy)
  );

  // stage a: decode done, ram read in flight
  logic [7:0]       a_rd;
  logic             a_ram_rd;
  logic             a_ready;
  evct_rom_result_t a_rom;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_rd     <= (cmd == CMD_STATUS) ?
                  (8'(tstat.time_over) << STATUS_TIME_OVER_BIT) : 8'h00;
      a_ram_rd <= (cmd == CMD_RAM_RD);
      a_ready  <= tstat.score_fire;
      a_rom    <= (cmd == CMD_ROM) ? rom : '0;
    end
  end

  // output register; ram_q holds until the next ram read is accepted
  logic [7:0]       o_rd;
  logic             o_ready;
  evct_rom_result_t o_rom;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (a_advance) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      o_rd    <= a_ram_rd ? ram_q : a_rd;
      o_ready <= a_ready;
      o_rom   <= a_rom;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {6'd0, o_ready, o_rom.hit, o_rom.address, o_rom.chip, o_rd};

endmodule

[rtl/core/evct_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evct_ram
// Cartridge work RAM: one write port, one registered read port, and a
// clearing sweep after reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module evct_ram import evct_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] addr,
  input  logic          wr_en,
  input  logic [7:0]    wdata,
  input  logic          rd_en,
  output logic [7:0]    rdata,
  output logic          busy
);

  logic [7:0]    mem [DEPTH];
  logic          clearing;
  logic [AW-1:0] clr_addr;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/core/evct_timer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evct_timer
// Game timer, score countdown, time-over flag and select register.
// ----------------------------------------------------------------------------
module evct_timer import evct_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  evct_cmd_t          cmd,
  input  logic [7:0]         write_data,
  input  logic [15:0]        timer_seconds,
  output evct_timer_status_t status
);

  logic        time_over;
  logic [7:0]  select_value;
  logic        game_running;
  logic        score_pending;
  logic [15:0] game_left;
  logic [2:0]  score_left;

  logic        time_over_next;
  logic [7:0]  select_value_next;
  logic        game_running_next;
  logic        score_pending_next;
  logic [15:0] game_left_next;
  logic [2:0]  score_left_next;
  logic        fire;

  always_comb begin
    time_over_next     = time_over;
    select_value_next  = select_value;
    game_running_next  = game_running;
    score_pending_next = score_pending;
    game_left_next     = game_left;
    score_left_next    = score_left;
    fire               = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_TICK: begin
          // score countdown steps before the game timer
          if (score_pending && (score_left != 3'd0)) begin
            score_left_next = score_left - 3'd1;
            if (score_left == 3'd1) begin
              score_pending_next = 1'b0;
              fire               = 1'b1;
            end
          end
          if (game_running && (game_left != 16'd0)) begin
            game_left_next = game_left - 16'd1;
            if (game_left == 16'd1) begin
              game_running_next  = 1'b0;
              time_over_next     = 1'b1;
              score_pending_next = 1'b1;
              score_left_next    = SCORE_SECONDS;
            end
          end
        end
        CMD_SELECT: begin
          select_value_next = write_data;
          if ((timer_seconds != 16'd0) && (write_data == SEL_GAME_START)) begin
            game_running_next = 1'b1;
            game_left_next    = timer_seconds;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_over     <= 1'b0;
      select_value  <= 8'h00;
      game_running  <= 1'b0;
      score_pending <= 1'b0;
      game_left     <= 16'd0;
      score_left    <= 3'd0;
    end else begin
      time_over     <= time_over_next;
      select_value  <= select_value_next;
      game_running  <= game_running_next;
      score_pending <= score_pending_next;
      game_left     <= game_left_next;
      score_left    <= score_left_next;
    end
  end

  assign status.time_over    = time_over;
  assign status.score_fire   = fire;
  assign status.select_value = select_value;

endmodule

[rtl/core/evct_rom_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evct_rom_map
// Decodes a bus address into a ROM chip and mirrored chip address for the
// campus and powerfest board layouts.
// ----------------------------------------------------------------------------
module evct_rom_map import evct_pkg::*; (
  input  logic [1:0]       board_kind,
  input  logic [7:0]       select_value,
  input  logic [23:0]      address,
  input  logic [4:0]       chip_log2 [4],
  output evct_rom_result_t result
);

  logic [1:0]  id;
  logic        hit;
  logic [23:0] mapped;
  logic [4:0]  lg;
  logic [21:0] mask;

  always_comb begin
    id     = 2'd0;
    hit    = 1'b0;
    mapped = 24'h0;
    case (board_kind)
      BOARD_CAMPUS: begin
        if (select_value == SEL_GAME_START) id = 2'd1;
        if (select_value == SEL_CAMPUS_2)   id = 2'd2;
        if (select_value == SEL_CAMPUS_3)   id = 2'd3;
        if ((address & CAMPUS_CHIP0_MASK) == CAMPUS_CHIP0_MASK) id = 2'd0;
        if (address[15]) begin
          hit    = 1'b1;
          mapped = ((address & BANK_LO_MASK) >> 1) | (address & OFFSET_MASK);
        end
      end
      BOARD_POWERFEST: begin
        if (select_value == SEL_GAME_START) id = 2'd1;
        if (select_value == SEL_POWER_2)    id = 2'd2;
        if (select_value == SEL_POWER_3)    id = 2'd3;
        if ((address & POWER_CHIP0_MASK) == POWER_CHIP0_MASK) id = 2'd0;
        if (address[22]) begin
          hit    = 1'b1;
          mapped = address & POWER_HI_MASK;
        end else if (address[15]) begin
          hit = 1'b1;
          if (id == 2'd2) begin
            mapped = address & POWER_LO_MASK;
          end else begin
            mapped = ((address & POWER_BANK_MASK) >> 1) | (address & OFFSET_MASK);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // clamp the chip size and build its mirror mask
  always_comb begin
    lg = chip_log2[id];
    if (lg < LOG2_MIN) lg = LOG2_MIN;
    if (lg > LOG2_MAX) lg = LOG2_MAX;
    for (int i = 0; i < 22; i++) begin
      mask[i] = (5'(i) < lg);
    end
  end

  assign result.hit     = hit;
  assign result.chip    = hit ? id : 2'd0;
  assign result.address = hit ? (mapped[21:0] & mask) : 22'h0;

endmodule

[rtl/core/evct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// evct_checker
// Port-level checks for the event cartridge controller, bound to the top.
// ----------------------------------------------------------------------------
module evct_checker import evct_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // reset starts the ram sweep and empties the output
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> (!s_tready && !m_tvalid))
    else $error("ready or valid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed");

  // a score pulse only comes from a tick, never from a rom read
  a_score_not_rom: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33]) |-> (!m_tdata[32] && (m_tdata[31:8] == 24'd0)))
    else $error("score pulse on a rom word");

  a_open_bus_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[32]) |-> (m_tdata[31:8] == 24'd0))
    else $error("chip or rom address set without a hit");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:34] == 6'd0))
    else $error("padding bits set");

endmodule

bind event_cart_timer_and_rom_mapper evct_checker u_evct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
